### rtl/core/mosa_pkg.sv
// ----------------------------------------------------------------------------
// mosa_pkg: shared definitions for the oversampling averager
// Register codes, register widths, default sizes, state types and width helpers.
// ----------------------------------------------------------------------------
package mosa_pkg;

   // configuration register file
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 11;
   localparam int CHANNEL_COUNT_W   = 5;
   localparam int OVERSAMPLE_W      = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERSAMPLE_FACTOR = 1'b1;

   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 5'd1;
   localparam logic [OVERSAMPLE_W-1:0]    OVERSAMPLE_RESET    = 11'd1;

   // default sizes
   localparam int DEF_MAX_CHANNELS   = 16;
   localparam int DEF_MAX_OVERSAMPLE = 1024;
   localparam int DEF_SAMPLE_BITS    = 16;

   // width of an index into n entries, at least one bit
   function automatic int idx_width(input int n);
      int w;
      begin
         w = (n > 1) ? $clog2(n) : 1;
         return w;
      end
   endfunction

   // width that holds the value n itself
   function automatic int val_width(input int n);
      int w;
      begin
         w = (n > 0) ? $clog2(n + 1) : 1;
         return w;
      end
   endfunction

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_ACC,
      FE_DRAIN_RD,
      FE_DRAIN_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_HOLD
   } back_state_type;

endpackage

### rtl/core/mosa_queue.sv
// ----------------------------------------------------------------------------
// mosa_queue: two-entry transaction queue
// Decouples the accumulating front end from the dividing back end.
// ----------------------------------------------------------------------------
module mosa_queue import mosa_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   always_comb begin
      in_ready  = (count_ff != 2'd2);
      out_valid = (count_ff != 2'd0);
      out_data  = entry_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/core/mosa_front.sv
// ----------------------------------------------------------------------------
// mosa_front: sample intake and per-channel accumulation
// Adds each sample into its channel sum, tracks pointer and scan count, and
// drains the sums into the queue when an output scan is due.
// ----------------------------------------------------------------------------
module mosa_front import mosa_pkg::*; #(
   parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
   parameter int MAX_OVERSAMPLE = DEF_MAX_OVERSAMPLE,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   localparam int CH_W  = idx_width(MAX_CHANNELS),
   localparam int N_W   = val_width(MAX_CHANNELS),
   localparam int F_W   = val_width(MAX_OVERSAMPLE),
   localparam int CNT_W = idx_width(MAX_OVERSAMPLE),
   localparam int SUM_W = SAMPLE_BITS + CNT_W,
   localparam int Q_W   = CH_W + SUM_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [N_W-1:0]         eff_n,
   input  logic [F_W-1:0]         eff_f,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   output logic                   q_valid_o,
   input  logic                   q_ready_i,
   output logic [Q_W-1:0]         q_data_o
);

   front_state_type         state_ff, state_in;
   logic [CH_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CH_W-1:0]         drain_ff, drain_in;
   logic [MAX_CHANNELS-1:0] vld_ff, vld_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [SUM_W-1:0]        rd_data_ff;
   logic [SUM_W-1:0]        sums_mem [MAX_CHANNELS];
   logic [CH_W-1:0]         rd_addr;
   logic                    mem_we;
   logic [SUM_W-1:0]        acc_sum;
   logic [SUM_W-1:0]        drain_sum;
   logic                    scan_end, emit, drain_last;

   always_comb begin
      rd_addr    = (state_ff == FE_DRAIN_RD || state_ff == FE_DRAIN_PUSH) ? drain_ff : ptr_ff;
      acc_sum    = (vld_ff[ptr_ff] ? rd_data_ff : '0) + SUM_W'(sample_ff);
      drain_sum  = vld_ff[drain_ff] ? rd_data_ff : '0;
      scan_end   = (32'(ptr_ff) + 32'd1) >= 32'(eff_n);
      emit       = (32'(cnt_ff) + 32'd1) >= 32'(eff_f);
      drain_last = (32'(drain_ff) + 32'd1) >= 32'(eff_n);
      q_data_o   = {drain_ff, drain_sum, drain_last};

      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      drain_in  = drain_ff;
      vld_in    = vld_ff;
      mem_we    = 1'b0;
      q_valid_o = 1'b0;
      req_ready = (state_ff == FE_IDLE);
      sample_in = (req_valid && req_ready) ? req_raw_sample : sample_ff;

      case (state_ff)
         FE_IDLE: begin
            if (req_valid) begin
               state_in = FE_ACC;
            end
         end
         FE_ACC: begin
            mem_we         = 1'b1;
            vld_in[ptr_ff] = 1'b1;
            if (scan_end) begin
               ptr_in = '0;
               if (emit) begin
                  cnt_in   = '0;
                  drain_in = '0;
                  state_in = FE_DRAIN_RD;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = FE_IDLE;
               end
            end else begin
               ptr_in   = ptr_ff + CH_W'(1);
               state_in = FE_IDLE;
            end
         end
         FE_DRAIN_RD: begin
            state_in = FE_DRAIN_PUSH;
         end
         FE_DRAIN_PUSH: begin
            q_valid_o = 1'b1;
            if (q_ready_i) begin
               if (drain_last) begin
                  // scan emitted: every sum restarts from zero
                  vld_in   = '0;
                  state_in = FE_IDLE;
               end else begin
                  drain_in = drain_ff + CH_W'(1);
                  state_in = FE_DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
         drain_ff <= '0;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         drain_ff <= drain_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   // channel sums
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[ptr_ff] <= acc_sum;
      end
      rd_data_ff <= sums_mem[rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) < MAX_CHANNELS)
      else $error("channel pointer out of range");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == FE_ACC && sample_ff == $past(req_raw_sample)))
      else $error("accepted sample not captured for accumulation");

   assert property (@(posedge clock) disable iff (reset)
      q_valid_o |-> (32'(drain_ff) < 32'(eff_n)))
      else $error("drain index beyond channel count");

   assert property (@(posedge clock) disable iff (reset)
      (q_valid_o && q_ready_i && drain_last) |=> (vld_ff == '0 && cnt_ff == '0))
      else $error("sums not cleared after emission");

endmodule

### rtl/core/mosa_back.sv
// ----------------------------------------------------------------------------
// mosa_back: per-channel divide and result register
// Restoring divider, one quotient bit per cycle, feeding the rsp_ channel.
// ----------------------------------------------------------------------------
module mosa_back import mosa_pkg::*; #(
   parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
   parameter int MAX_OVERSAMPLE = DEF_MAX_OVERSAMPLE,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   localparam int CH_W  = idx_width(MAX_CHANNELS),
   localparam int F_W   = val_width(MAX_OVERSAMPLE),
   localparam int CNT_W = idx_width(MAX_OVERSAMPLE),
   localparam int SUM_W = SAMPLE_BITS + CNT_W,
   localparam int Q_W   = CH_W + SUM_W + 1,
   localparam int DC_W  = idx_width(SUM_W)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [F_W-1:0]         eff_f,
   input  logic                   q_valid_i,
   output logic                   q_ready_o,
   input  logic [Q_W-1:0]         q_data_i,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CH_W-1:0]        rsp_channel_index,
   output logic [SAMPLE_BITS-1:0] rsp_average_value,
   output logic                   rsp_last_of_scan
);

   back_state_type         state_ff, state_in;
   logic [F_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic [DC_W-1:0]        step_ff, step_in;
   logic [CH_W-1:0]        idx_ff, idx_in;
   logic                   last_ff, last_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CH_W-1:0]        out_idx_ff, out_idx_in;
   logic [SAMPLE_BITS-1:0] out_avg_ff, out_avg_in;
   logic                   out_last_ff, out_last_in;
   logic [F_W:0]           shifted;
   logic                   q_bit;
   logic                   out_free;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      q_bit   = (shifted >= {1'b0, eff_f});
      out_free = !out_valid_ff || rsp_ready;

      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_idx_in   = out_idx_ff;
      out_avg_in   = out_avg_ff;
      out_last_in  = out_last_ff;
      q_ready_o    = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            q_ready_o = 1'b1;
            if (q_valid_i) begin
               idx_in   = q_data_i[Q_W-1 -: CH_W];
               quo_in   = q_data_i[SUM_W:1];
               last_in  = q_data_i[0];
               rem_in   = '0;
               step_in  = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in  = q_bit ? F_W'(shifted - {1'b0, eff_f}) : F_W'(shifted);
            quo_in  = {quo_ff[SUM_W-2:0], q_bit};
            step_in = step_ff + DC_W'(1);
            if (step_ff == DC_W'(SUM_W - 1)) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = idx_ff;
               out_avg_in   = quo_ff[SAMPLE_BITS-1:0];
               out_last_in  = last_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid         = out_valid_ff;
      rsp_channel_index = out_idx_ff;
      rsp_average_value = out_avg_ff;
      rsp_last_of_scan  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      out_idx_ff  <= out_idx_in;
      out_avg_ff  <= out_avg_in;
      out_last_ff <= out_last_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (32'(rem_ff) < 32'(eff_f)))
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_HOLD && out_free) |=> (rsp_valid && state_ff == BK_IDLE))
      else $error("finished quotient not moved to result register");

   assert property (@(posedge clock) disable iff (reset)
      (q_valid_i && q_ready_o) |=> (state_ff == BK_DIV && step_ff == '0))
      else $error("popped transaction did not start a divide");

endmodule

### rtl/core/multichannel_oversample_averager.sv
// ----------------------------------------------------------------------------
// multichannel_oversample_averager: boxcar decimation over interleaved channels
// Sums round-robin samples per channel and emits one averaged scan every
// oversample_factor scans.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one raw converter code per transaction, channels in
//   round-robin order starting at channel 0. Each sample occupies the front
//   end for a read of the channel sum, then an add and write back, and
//   req_ready is low until that is done, so samples are taken one at a time.
//   rsp_ channel: when a scan end completes the oversampling window, one
//   transaction per channel (0 .. channel_count-1, as clamped) carries sum / factor,
//   truncated, with rsp_last_of_scan on the final channel.
//   Drain: the front end moves the channel sums one at a time (read, then
//   push) into a two-entry queue; the back end divides each sum with a
//   restoring divider at one quotient bit per cycle, then loads it into the
//   result register. req_ready stays low until the last sum has entered
//   the queue.
//   Stall: if rsp_ready is low the result register holds, the divider holds
//   its quotient, the queue fills and the front end holds the drain.
//   Reset: channel pointer, scan counter and all sum valid flags clear
//   together (no clearing pass); channel_count and oversample_factor return to 1.
//   csr_ writes apply from the next sample; write only while idle.
// ----------------------------------------------------------------------------
module multichannel_oversample_averager import mosa_pkg::*; #(
   parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
   parameter int MAX_OVERSAMPLE = DEF_MAX_OVERSAMPLE,
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   localparam int CH_W  = idx_width(MAX_CHANNELS),
   localparam int N_W   = val_width(MAX_CHANNELS),
   localparam int F_W   = val_width(MAX_OVERSAMPLE),
   localparam int CNT_W = idx_width(MAX_OVERSAMPLE),
   localparam int SUM_W = SAMPLE_BITS + CNT_W,
   localparam int Q_W   = CH_W + SUM_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // samples
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_raw_sample,
   // averaged results
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CH_W-1:0]        rsp_channel_index,
   output logic [SAMPLE_BITS-1:0] rsp_average_value,
   output logic                   rsp_last_of_scan
);

   logic [CHANNEL_COUNT_W-1:0] chan_count_ff, chan_count_in;
   logic [OVERSAMPLE_W-1:0]    factor_ff, factor_in;
   logic [N_W-1:0]             eff_n;
   logic [F_W-1:0]             eff_f;
   logic                       q_in_valid, q_in_ready;
   logic [Q_W-1:0]             q_in_data;
   logic                       q_out_valid, q_out_ready;
   logic [Q_W-1:0]             q_out_data;

   // register writes; unknown indexes are dropped
   always_comb begin
      chan_count_in = chan_count_ff;
      factor_in     = factor_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: begin
               chan_count_in = csr_wdata[CHANNEL_COUNT_W-1:0];
            end
            CSR_OVERSAMPLE_FACTOR: begin
               factor_in = csr_wdata[OVERSAMPLE_W-1:0];
            end
            default: begin
               chan_count_in = chan_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CHANNEL_COUNT_RESET;
         factor_ff     <= OVERSAMPLE_RESET;
      end else begin
         chan_count_ff <= chan_count_in;
         factor_ff     <= factor_in;
      end
   end

   // clamp the registers: zero acts as one, large values saturate
   always_comb begin
      if (chan_count_ff == '0) begin
         eff_n = N_W'(1);
      end else if (32'(chan_count_ff) > 32'(MAX_CHANNELS)) begin
         eff_n = N_W'(MAX_CHANNELS);
      end else begin
         eff_n = N_W'(chan_count_ff);
      end

      if (factor_ff == '0) begin
         eff_f = F_W'(1);
      end else if (32'(factor_ff) > 32'(MAX_OVERSAMPLE)) begin
         eff_f = F_W'(MAX_OVERSAMPLE);
      end else begin
         eff_f = F_W'(factor_ff);
      end
   end

   // front end: accumulate, then drain sums when the window closes
   mosa_front #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_OVERSAMPLE(MAX_OVERSAMPLE),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .eff_n         (eff_n),
      .eff_f         (eff_f),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_raw_sample(req_raw_sample),
      .q_valid_o     (q_in_valid),
      .q_ready_i     (q_in_ready),
      .q_data_o      (q_in_data)
   );

   // queue of {channel, sum, last} transactions between the two halves
   mosa_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_in_valid),
      .in_ready (q_in_ready),
      .in_data  (q_in_data),
      .out_valid(q_out_valid),
      .out_ready(q_out_ready),
      .out_data (q_out_data)
   );

   // back end: divide each sum by the factor and hand it out
   mosa_back #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_OVERSAMPLE(MAX_OVERSAMPLE),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .eff_f            (eff_f),
      .q_valid_i        (q_out_valid),
      .q_ready_o        (q_out_ready),
      .q_data_i         (q_out_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_index(rsp_channel_index),
      .rsp_average_value(rsp_average_value),
      .rsp_last_of_scan (rsp_last_of_scan)
   );

endmodule
